[hw/rtl/tsc_pkg.sv]
// Shared types and constants for the touch sample conditioner.
// No dependencies; imported by every module of the block.
package tsc_pkg;

    // Field widths
    localparam int ADC_W    = 10;
    localparam int SCREEN_W = 12;
    localparam int STEP_W   = $clog2(ADC_W + 1);

    // Parameter defaults
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAFE_Y_DEF      = 240;

    // Fewest samples a press needs to yield a calibration pair
    localparam int MIN_CALIB_SAMPLES = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COLLECT_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd1;

    // One result beat
    typedef struct packed {
        logic                       pressed;
        logic signed [SCREEN_W-1:0] point_x;
        logic signed [SCREEN_W-1:0] point_y;
        logic signed [SCREEN_W-1:0] report_x;
        logic signed [SCREEN_W-1:0] report_y;
        logic                       active;
        logic                       calib_done;
        logic [ADC_W-1:0]           calib_x;
        logic [ADC_W-1:0]           calib_y;
        logic [ADC_W-1:0]           last_adc_x;
        logic [ADC_W-1:0]           last_adc_y;
    } res_t;

endpackage

[hw/rtl/touch_sample_conditioner_core.sv]
// Path: an accepted poll's result is registered in the result stage, then moves to the output
// register; a release that yields a calibration pair first waits in ST_DIV for the ADC_W (10)
// serial divider steps, and the quotient is then collected into the result stage.
// Flow: a new poll is taken only while the result stage is empty and no division runs, so
// output back-pressure holds polls; the divider produces one quotient bit per cycle.
// Reset (aresetn, synchronous, active low): released, no point, sums cleared,
// collect mode off, filtering on, no result pending.
module touch_sample_conditioner_core
    import tsc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAFE_Y      = SAFE_Y_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic                       cfg_wdata,
    // Poll channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_pen_down,
    input  logic                       s_adc_ok,
    input  logic [ADC_W-1:0]           s_adc_x,
    input  logic [ADC_W-1:0]           s_adc_y,
    input  logic                       s_map_ok,
    input  logic signed [SCREEN_W-1:0] s_screen_x,
    input  logic signed [SCREEN_W-1:0] s_screen_y,
    // Result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_pressed,
    output logic signed [SCREEN_W-1:0] m_point_x,
    output logic signed [SCREEN_W-1:0] m_point_y,
    output logic signed [SCREEN_W-1:0] m_report_x,
    output logic signed [SCREEN_W-1:0] m_report_y,
    output logic                       m_active,
    output logic                       m_calib_done,
    output logic [ADC_W-1:0]           m_calib_x,
    output logic [ADC_W-1:0]           m_calib_y,
    output logic [ADC_W-1:0]           m_last_adc_x,
    output logic [ADC_W-1:0]           m_last_adc_y
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = ADC_W + CNT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic             state_reg, state_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    res_t             m_res_reg, m_res_next;

    logic             accept;
    logic             load_out;
    res_t             trk_res;
    logic             calib_go;
    logic [SUM_W-1:0] sum_x, sum_y;
    logic [CNT_W-1:0] count;
    logic             div_done;
    logic [ADC_W-1:0] quot_x, quot_y;

    assign s_ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign accept  = s_valid && s_ready;

    tsc_tracker #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAFE_Y      (SAFE_Y)
    ) u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .pen_down  (s_pen_down),
        .adc_ok    (s_adc_ok),
        .adc_x     (s_adc_x),
        .adc_y     (s_adc_y),
        .map_ok    (s_map_ok),
        .screen_x  (s_screen_x),
        .screen_y  (s_screen_y),
        .res       (trk_res),
        .calib_go  (calib_go),
        .sum_x     (sum_x),
        .sum_y     (sum_y),
        .count     (count)
    );

    tsc_divider #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept && calib_go),
        .dividend_x (sum_x),
        .dividend_y (sum_y),
        .divisor    (count),
        .done       (div_done),
        .quot_x     (quot_x),
        .quot_y     (quot_y)
    );

    // Move a finished result into the output register when it is free or being drained
    assign load_out = res_valid_reg && (!m_valid_reg || m_ready);

    // Result stage and divider wait
    always_comb begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_res_next     = m_res_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next   = 1'b1;
            m_res_next     = res_reg;
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next = trk_res;
                    if (calib_go) begin
                        state_next = ST_DIV;
                    end else begin
                        res_valid_next = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                // Hold the beat until the averaged pair is in
                if (div_done) begin
                    res_next.calib_x = quot_x;
                    res_next.calib_y = quot_y;
                    res_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_pressed    = m_res_reg.pressed;
    assign m_point_x    = m_res_reg.point_x;
    assign m_point_y    = m_res_reg.point_y;
    assign m_report_x   = m_res_reg.report_x;
    assign m_report_y   = m_res_reg.report_y;
    assign m_active     = m_res_reg.active;
    assign m_calib_done = m_res_reg.calib_done;
    assign m_calib_x    = m_res_reg.calib_x;
    assign m_calib_y    = m_res_reg.calib_y;
    assign m_last_adc_x = m_res_reg.last_adc_x;
    assign m_last_adc_y = m_res_reg.last_adc_y;

    // A pending result never coexists with a division in flight
    a_no_res_during_div: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == ST_DIV && res_valid_reg))
        else $error("result pending while dividing");

    // The divider only finishes while the sequencer waits for it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait");

    // A calibration release enters the divider wait on the next cycle
    a_calib_enters_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && calib_go) |=> (state_reg == ST_DIV))
        else $error("calibration release did not start a division");

    // A calibration pulse only ever comes with the released state
    a_calib_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_calib_done) |-> !m_pressed)
        else $error("calibration pulse while pressed");

endmodule

[hw/rtl/tsc_divider.sv]
// Bit-serial restoring divider: two lanes share one divisor, one quotient bit per cycle.
// Depends on tsc_pkg.
module tsc_divider
    import tsc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [ADC_W+$clog2(MAX_SAMPLES+1)-1:0] dividend_x,
    input  logic [ADC_W+$clog2(MAX_SAMPLES+1)-1:0] dividend_y,
    input  logic [$clog2(MAX_SAMPLES+1)-1:0]    divisor,
    output logic                                done,
    output logic [ADC_W-1:0]                    quot_x,
    output logic [ADC_W-1:0]                    quot_y
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = ADC_W + CNT_W;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]  rem_x_reg, rem_y_reg;
    logic [ADC_W-1:0]  dvd_x_reg, dvd_y_reg;
    logic [ADC_W-1:0]  q_x_reg, q_y_reg;

    logic [CNT_W:0]    trial_x, trial_y;
    logic              ge_x, ge_y;
    logic [CNT_W-1:0]  rem_x_next, rem_y_next;

    // Trial subtract: bring down the next dividend bit, keep the difference if it fits
    always_comb begin
        trial_x    = {rem_x_reg, dvd_x_reg[ADC_W-1]};
        trial_y    = {rem_y_reg, dvd_y_reg[ADC_W-1]};
        ge_x       = trial_x >= {1'b0, divisor_reg};
        ge_y       = trial_y >= {1'b0, divisor_reg};
        rem_x_next = ge_x ? CNT_W'(trial_x - {1'b0, divisor_reg}) : trial_x[CNT_W-1:0];
        rem_y_next = ge_y ? CNT_W'(trial_y - {1'b0, divisor_reg}) : trial_y[CNT_W-1:0];
    end

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ADC_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the high part of the sum is already below the divisor, as the mean fits ADC_W bits
    always_ff @(posedge aclk) begin
        if (start) begin
            divisor_reg <= divisor;
            rem_x_reg   <= dividend_x[SUM_W-1:ADC_W];
            rem_y_reg   <= dividend_y[SUM_W-1:ADC_W];
            dvd_x_reg   <= dividend_x[ADC_W-1:0];
            dvd_y_reg   <= dividend_y[ADC_W-1:0];
        end else if (busy_reg) begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            dvd_x_reg <= {dvd_x_reg[ADC_W-2:0], 1'b0};
            dvd_y_reg <= {dvd_y_reg[ADC_W-2:0], 1'b0};
            q_x_reg   <= {q_x_reg[ADC_W-2:0], ge_x};
            q_y_reg   <= {q_y_reg[ADC_W-2:0], ge_y};
        end
    end

    assign done   = done_reg;
    assign quot_x = q_x_reg;
    assign quot_y = q_y_reg;

endmodule

[hw/rtl/tsc_tracker.sv]
// Touch tracking state, calibration sums, IIR smoothing and configuration registers.
// Depends on tsc_pkg; builds the result beat for each accepted poll.
module tsc_tracker
    import tsc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAFE_Y      = SAFE_Y_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic                                   cfg_wdata,
    input  logic                                   accept,
    input  logic                                   pen_down,
    input  logic                                   adc_ok,
    input  logic [ADC_W-1:0]                       adc_x,
    input  logic [ADC_W-1:0]                       adc_y,
    input  logic                                   map_ok,
    input  logic signed [SCREEN_W-1:0]             screen_x,
    input  logic signed [SCREEN_W-1:0]             screen_y,
    output res_t                                   res,
    output logic                                   calib_go,
    output logic [ADC_W+$clog2(MAX_SAMPLES+1)-1:0] sum_x,
    output logic [ADC_W+$clog2(MAX_SAMPLES+1)-1:0] sum_y,
    output logic [$clog2(MAX_SAMPLES+1)-1:0]       count
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = ADC_W + CNT_W;

    logic collect_reg, collect_next;
    logic filter_en_reg, filter_en_next;
    logic pressed_reg, pressed_next;
    logic armed_reg, armed_next;
    logic pvalid_reg, pvalid_next;
    logic cwp_reg, cwp_next;
    logic signed [SCREEN_W-1:0] smooth_x_reg, smooth_x_next;
    logic signed [SCREEN_W-1:0] smooth_y_reg, smooth_y_next;
    logic signed [SCREEN_W-1:0] rep_x_reg, rep_x_next;
    logic signed [SCREEN_W-1:0] rep_y_reg, rep_y_next;
    logic [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ADC_W-1:0] last_x_reg, last_x_next;
    logic [ADC_W-1:0] last_y_reg, last_y_next;

    logic signed [SCREEN_W-1:0] sx, sy;
    logic [SUM_W-1:0] base_sum_x, base_sum_y;
    logic [CNT_W-1:0] base_count;

    // Three-quarter IIR step: (3*s + v) / 4, truncating toward zero
    function automatic logic signed [SCREEN_W-1:0] iir_step(
        input logic signed [SCREEN_W-1:0] s,
        input logic signed [SCREEN_W-1:0] v
    );
        logic signed [SCREEN_W+1:0] s_w;
        logic signed [SCREEN_W+1:0] v_w;
        logic signed [SCREEN_W+1:0] t;
        logic signed [SCREEN_W+1:0] q;
        s_w = {{2{s[SCREEN_W-1]}}, s};
        v_w = {{2{v[SCREEN_W-1]}}, v};
        t   = (s_w <<< 1) + s_w + v_w;
        if (t[SCREEN_W+1]) begin
            q = (t + (SCREEN_W+2)'(3)) >>> 2;
        end else begin
            q = t >>> 2;
        end
        return q[SCREEN_W-1:0];
    endfunction

    assign sx = map_ok ? screen_x : '0;
    assign sy = map_ok ? screen_y : '0;

    // Next state for register writes and accepted polls
    always_comb begin
        collect_next   = collect_reg;
        filter_en_next = filter_en_reg;
        pressed_next   = pressed_reg;
        armed_next     = armed_reg;
        pvalid_next    = pvalid_reg;
        cwp_next       = cwp_reg;
        smooth_x_next  = smooth_x_reg;
        smooth_y_next  = smooth_y_reg;
        rep_x_next     = rep_x_reg;
        rep_y_next     = rep_y_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        count_next     = count_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        calib_go       = 1'b0;
        base_sum_x     = cwp_reg ? sum_x_reg : '0;
        base_sum_y     = cwp_reg ? sum_y_reg : '0;
        base_count     = cwp_reg ? count_reg : '0;

        // Register writes: a mode write drops collect tracking, a write of 0 also releases
        if (cfg_wr_en && cfg_index == REG_COLLECT_MODE) begin
            collect_next = cfg_wdata;
            cwp_next     = 1'b0;
            sum_x_next   = '0;
            sum_y_next   = '0;
            count_next   = '0;
            if (!cfg_wdata) begin
                pressed_next  = 1'b0;
                armed_next    = 1'b0;
                pvalid_next   = 1'b0;
                smooth_x_next = '0;
                smooth_y_next = '0;
                rep_x_next    = '0;
                rep_y_next    = '0;
            end
        end else if (cfg_wr_en && cfg_index == REG_FILTER_ENABLE) begin
            filter_en_next = cfg_wdata;
        end

        if (accept) begin
            priority if (!pen_down) begin
                // Release: end the press, hand a long enough collect press to the divider
                if (collect_reg && cwp_reg) begin
                    calib_go   = count_reg >= CNT_W'(MIN_CALIB_SAMPLES);
                    sum_x_next = '0;
                    sum_y_next = '0;
                    count_next = '0;
                end
                cwp_next      = 1'b0;
                pressed_next  = 1'b0;
                armed_next    = 1'b0;
                pvalid_next   = 1'b0;
                smooth_x_next = '0;
                smooth_y_next = '0;
                rep_x_next    = '0;
                rep_y_next    = '0;
            end else if (!adc_ok) begin
                // Failed read: hold the point, stay pressed
                pressed_next = 1'b1;
                if (armed_reg) begin
                    pvalid_next = 1'b1;
                end
            end else begin
                last_x_next  = adc_x;
                last_y_next  = adc_y;
                pressed_next = 1'b1;
                if (collect_reg) begin
                    // Accumulate until the count saturates
                    sum_x_next = base_sum_x;
                    sum_y_next = base_sum_y;
                    count_next = base_count;
                    if (base_count < CNT_W'(MAX_SAMPLES)) begin
                        sum_x_next = base_sum_x + SUM_W'(adc_x);
                        sum_y_next = base_sum_y + SUM_W'(adc_y);
                        count_next = base_count + 1'b1;
                    end
                    cwp_next = 1'b1;
                end else begin
                    // Load the first point of a press, or every point with filtering off, directly; smooth the rest
                    if (!filter_en_reg || !armed_reg || !pressed_reg) begin
                        smooth_x_next = sx;
                        smooth_y_next = sy;
                    end else begin
                        smooth_x_next = iir_step(smooth_x_reg, sx);
                        smooth_y_next = iir_step(smooth_y_reg, sy);
                    end
                    armed_next  = 1'b1;
                    pvalid_next = 1'b1;
                    rep_x_next  = smooth_x_next;
                    rep_y_next  = smooth_y_next;
                end
            end
        end
    end

    // Result beat from the updated state
    always_comb begin
        res.pressed    = pressed_next;
        res.point_x    = pvalid_next ? smooth_x_next : '0;
        res.point_y    = pvalid_next ? smooth_y_next : SCREEN_W'(SAFE_Y);
        res.report_x   = rep_x_next;
        res.report_y   = rep_y_next;
        res.active     = (rep_x_next != '0) || (rep_y_next != '0) || pressed_next;
        res.calib_done = calib_go;
        res.calib_x    = '0;
        res.calib_y    = '0;
        res.last_adc_x = last_x_next;
        res.last_adc_y = last_y_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collect_reg   <= 1'b0;
            filter_en_reg <= 1'b1;
            pressed_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            pvalid_reg    <= 1'b0;
            cwp_reg       <= 1'b0;
            smooth_x_reg  <= '0;
            smooth_y_reg  <= '0;
            rep_x_reg     <= '0;
            rep_y_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
        end else begin
            collect_reg   <= collect_next;
            filter_en_reg <= filter_en_next;
            pressed_reg   <= pressed_next;
            armed_reg     <= armed_next;
            pvalid_reg    <= pvalid_next;
            cwp_reg       <= cwp_next;
            smooth_x_reg  <= smooth_x_next;
            smooth_y_reg  <= smooth_y_next;
            rep_x_reg     <= rep_x_next;
            rep_y_reg     <= rep_y_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            count_reg     <= count_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
        end
    end

    // Sums and count before this poll's clear, for the divider to latch
    assign sum_x = sum_x_reg;
    assign sum_y = sum_y_reg;
    assign count = count_reg;

endmodule
